>>> rtl/dkimrbc_pkg.sv
package dkimrbc_pkg;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam int unsigned CRLF_W = 16;
   localparam logic [CRLF_W-1:0] CRLF_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_BYTE
   } state_type;

endpackage

>>> rtl/dkimrbc_hold_ram.sv
module dkimrbc_hold_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dkim_relaxed_body_canon.sv
// Relaxed body canonicalization over a byte stream. Spaces, tabs, CR and LF
// bytes are absorbed and produce no transaction; a run of spaces and tabs is
// held as a single space and bare CRs are held in order, up to HOLD_DEPTH
// entries, and a line end drops them. A content byte with n held entries
// produces n + 1 response transactions, one per cycle while the output is
// not stalled, since every held entry is read back through the single read
// port of the hold buffer; the input stays stalled until the last one is in
// the output register. End of body gives one transaction carrying the final
// CRLF count. Held CRLF pairs saturate at 65535 and the hold buffer drops
// entries when full; both set the sticky overflow bit, which end of body
// clears along with the held entries, the pending CRLF count and the line
// state. The hold buffer needs no clearing pass after reset.
module dkim_relaxed_body_canon #(
   parameter int unsigned HOLD_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dkimrbc_pkg::CRLF_W-1:0]  rsp_crlf_pairs_before,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_body_done,
   output logic                            rsp_run_last,
   output logic                            rsp_overflow
);
   import dkimrbc_pkg::*;

   localparam int unsigned AW = $clog2(HOLD_DEPTH);
   localparam int unsigned LW = $clog2(HOLD_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [LW-1:0]      held_len_ff, held_len_in;
   logic               prev_space_ff, prev_space_in;
   logic [CRLF_W-1:0]  pending_ff, pending_in;
   logic               any_emitted_ff, any_emitted_in;
   logic               overflow_ff, overflow_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [7:0]         byte_ff, byte_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CRLF_W-1:0]  rsp_crlf_ff, rsp_crlf_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               out_free;
   logic               accept;
   logic               stall_c;
   logic               hold_req;
   logic               hold_bit;
   logic               wr_en;
   logic               rd_data;
   logic [AW-1:0]      rd_addr;
   logic               last_idx;

   dkimrbc_hold_ram #(
      .DEPTH (HOLD_DEPTH),
      .AW    (AW)
   ) u_hold (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (held_len_ff[AW-1:0]),
      .wr_data (hold_bit),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign stall_c  = !((state_ff == ST_IDLE) && out_free);
   assign accept   = req_valid && !stall_c;
   assign last_idx = (LW'(idx_ff) == held_len_ff - LW'(1));

   always_comb begin
      state_in       = state_ff;
      held_len_in    = held_len_ff;
      prev_space_in  = prev_space_ff;
      pending_in     = pending_ff;
      any_emitted_in = any_emitted_ff;
      overflow_in    = overflow_ff;
      idx_in         = idx_ff;
      byte_in        = byte_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_crlf_in    = rsp_crlf_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_bvalid_in  = rsp_bvalid_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      hold_req       = 1'b0;
      hold_bit       = 1'b0;
      wr_en          = 1'b0;
      rd_addr        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  rsp_valid_in   = 1'b1;
                  rsp_crlf_in    = any_emitted_ff ? CRLF_W'(1) : '0;
                  rsp_byte_in    = '0;
                  rsp_bvalid_in  = 1'b0;
                  rsp_done_in    = 1'b1;
                  rsp_last_in    = 1'b1;
                  rsp_ovf_in     = overflow_ff;
                  held_len_in    = '0;
                  prev_space_in  = 1'b0;
                  pending_in     = '0;
                  any_emitted_in = 1'b0;
                  overflow_in    = 1'b0;
               end else if (req_data_byte == CH_SPACE || req_data_byte == CH_TAB) begin
                  hold_req      = !prev_space_ff;
                  prev_space_in = 1'b1;
               end else if (req_data_byte == CH_CR) begin
                  hold_req      = 1'b1;
                  hold_bit      = 1'b1;
                  prev_space_in = 1'b0;
               end else if (req_data_byte == CH_LF) begin
                  held_len_in   = '0;
                  prev_space_in = 1'b0;
                  if (pending_ff != CRLF_MAX) begin
                     pending_in = pending_ff + CRLF_W'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else if (held_len_ff == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_crlf_in    = pending_ff;
                  rsp_byte_in    = req_data_byte;
                  rsp_bvalid_in  = 1'b1;
                  rsp_done_in    = 1'b0;
                  rsp_last_in    = 1'b1;
                  rsp_ovf_in     = overflow_ff;
                  pending_in     = '0;
                  prev_space_in  = 1'b0;
                  any_emitted_in = 1'b1;
               end else begin
                  byte_in  = req_data_byte;
                  idx_in   = '0;
                  state_in = ST_FLUSH;
               end
               if (hold_req) begin
                  if (held_len_ff < LW'(HOLD_DEPTH)) begin
                     wr_en       = 1'b1;
                     held_len_in = held_len_ff + LW'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            rd_addr = idx_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_crlf_in   = (idx_ff == '0) ? pending_ff : '0;
               rsp_byte_in   = rd_data ? CH_CR : CH_SPACE;
               rsp_bvalid_in = 1'b1;
               rsp_done_in   = 1'b0;
               rsp_last_in   = 1'b0;
               rsp_ovf_in    = overflow_ff;
               if (last_idx) begin
                  rd_addr  = '0;
                  state_in = ST_BYTE;
               end else begin
                  rd_addr = idx_ff + AW'(1);
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_crlf_in    = '0;
               rsp_byte_in    = byte_ff;
               rsp_bvalid_in  = 1'b1;
               rsp_done_in    = 1'b0;
               rsp_last_in    = 1'b1;
               rsp_ovf_in     = overflow_ff;
               held_len_in    = '0;
               pending_in     = '0;
               prev_space_in  = 1'b0;
               any_emitted_in = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         held_len_ff    <= '0;
         prev_space_ff  <= 1'b0;
         pending_ff     <= '0;
         any_emitted_ff <= 1'b0;
         overflow_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         held_len_ff    <= held_len_in;
         prev_space_ff  <= prev_space_in;
         pending_ff     <= pending_in;
         any_emitted_ff <= any_emitted_in;
         overflow_ff    <= overflow_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      byte_ff       <= byte_in;
      rsp_crlf_ff   <= rsp_crlf_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign req_stall             = stall_c;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_crlf_pairs_before = rsp_crlf_ff;
   assign rsp_out_byte          = rsp_byte_ff;
   assign rsp_byte_valid        = rsp_bvalid_ff;
   assign rsp_body_done         = rsp_done_ff;
   assign rsp_run_last          = rsp_last_ff;
   assign rsp_overflow          = rsp_ovf_ff;

endmodule

>>> test/tb_dkim_relaxed_body_canon.sv
`timescale 1ns / 100ps

module tb_dkim_relaxed_body_canon;
   import dkimrbc_pkg::*;

   localparam int HOLD_DEPTH = 16;
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_EOB  = 1'b1;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_GUARD = 400000;
   localparam int LF_RUN = 24;

   typedef struct packed {
      logic [CRLF_W-1:0] crlf;
      logic [7:0]        data;
      logic              bvalid;
      logic              done;
      logic              last;
      logic              ovf;
   } canon_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic [7:0] req_data_byte = 8'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CRLF_W-1:0] rsp_crlf_pairs_before;
   logic [7:0] rsp_out_byte;
   logic rsp_byte_valid;
   logic rsp_body_done;
   logic rsp_run_last;
   logic rsp_overflow;

   // canonicalizer shadow state
   logic              prev_space;
   int                hold_len;
   logic              hold_cr [HOLD_DEPTH];
   logic [CRLF_W-1:0] pend_crlf;
   logic              emitted;
   logic              ovf_flag;

   canon_out_type canon_expected [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int bodies_done = 0;
   int ovf_results = 0;

   dkim_relaxed_body_canon #(.HOLD_DEPTH(HOLD_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_crlf_pairs_before(rsp_crlf_pairs_before),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_body_done(rsp_body_done),
      .rsp_run_last(rsp_run_last),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic string fmt_out(canon_out_type r);
      return $sformatf("crlf=%0d byte=%02h bvalid=%0b done=%0b last=%0b ovf=%0b",
                       r.crlf, r.data, r.bvalid, r.done, r.last, r.ovf);
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function automatic canon_out_type make_out(input logic [CRLF_W-1:0] crlf,
                                              input logic [7:0] data, input logic bvalid,
                                              input logic done, input logic last);
      canon_out_type r;
      r.crlf = crlf;
      r.data = data;
      r.bvalid = bvalid;
      r.done = done;
      r.last = last;
      r.ovf = ovf_flag;
      return r;
   endfunction

   task automatic canon_clear();
      prev_space = 1'b0;
      hold_len = 0;
      foreach (hold_cr[i]) hold_cr[i] = 1'b0;
      pend_crlf = '0;
      emitted = 1'b0;
      ovf_flag = 1'b0;
   endtask

   task automatic hold_push(input logic is_cr);
      if (hold_len < HOLD_DEPTH) begin
         hold_cr[hold_len] = is_cr;
         hold_len++;
      end else begin
         ovf_flag = 1'b1;
      end
   endtask

   // expected responses for one accepted transaction
   task automatic canon_apply(input logic mode, input logic [7:0] b);
      int i;
      if (mode == MODE_EOB) begin
         canon_expected.push_back(make_out(emitted ? CRLF_W'(1) : '0, 8'd0, 1'b0, 1'b1,
                                           1'b1));
         canon_clear();
      end else if (b == CH_SPACE || b == CH_TAB) begin
         if (!prev_space) hold_push(1'b0);
         prev_space = 1'b1;
      end else if (b == CH_CR) begin
         hold_push(1'b1);
         prev_space = 1'b0;
      end else if (b == CH_LF) begin
         hold_len = 0;
         if (pend_crlf != CRLF_MAX)
            pend_crlf++;
         else
            ovf_flag = 1'b1;
         prev_space = 1'b0;
      end else begin
         for (i = 0; i < hold_len; i++)
            canon_expected.push_back(make_out(i == 0 ? pend_crlf : '0,
                                              hold_cr[i] ? CH_CR : CH_SPACE,
                                              1'b1, 1'b0, 1'b0));
         canon_expected.push_back(make_out(hold_len == 0 ? pend_crlf : '0, b,
                                           1'b1, 1'b0, 1'b1));
         hold_len = 0;
         pend_crlf = '0;
         prev_space = 1'b0;
         emitted = 1'b1;
      end
   endtask

   task automatic send_item(input logic mode, input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      canon_apply(mode, b);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(MODE_BYTE, s[i]);
   endtask

   task automatic wait_drain(input int settle);
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (canon_expected.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (canon_expected.size() != 0) begin
         note_error($sformatf("%0d expected transactions never arrived",
                              canon_expected.size()));
         canon_expected.delete();
      end
      repeat (settle) @(posedge clock);
   endtask

   always @(posedge clock) begin
      canon_out_type got;
      canon_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_crlf_pairs_before, rsp_out_byte, rsp_byte_valid, rsp_body_done,
                rsp_run_last, rsp_overflow};
         results_seen++;
         if (got.done) bodies_done++;
         if (got.ovf) ovf_results++;
         if (canon_expected.size() == 0) begin
            note_error({"unexpected transaction: ", fmt_out(got)});
         end else begin
            want = canon_expected.pop_front();
            if (got !== want)
               note_error({"expected ", fmt_out(want), " got ", fmt_out(got)});
         end
      end
   end

   task automatic test_directed();
      idle_pct = 0;
      stall_pct = 0;
      send_item(MODE_EOB, 8'hFF);
      send_item(MODE_BYTE, 8'h00);
      send_item(MODE_BYTE, 8'hFF);
      send_text(" \t a");
      send_text("\rb");
      send_text(" \r\tc");
      send_text("x \r\n");
      send_text("\n\nd");
      send_text("\t\n");
      send_item(MODE_EOB, 8'h5A);
      wait_drain(SETTLE_CYCLES);
   endtask

   task automatic test_hold_full();
      stall_pct = 50;
      for (int i = 0; i < HOLD_DEPTH; i++)
         send_item(MODE_BYTE, CH_CR);
      send_item(MODE_BYTE, "y");
      for (int i = 0; i < HOLD_DEPTH; i++)
         send_text(" \r");
      send_item(MODE_BYTE, "z");
      send_item(MODE_EOB, 8'h00);
      send_item(MODE_BYTE, "q");
      send_item(MODE_EOB, 8'h00);
      wait_drain(SETTLE_CYCLES);
   endtask

   task automatic test_crlf_run();
      idle_pct = 0;
      stall_pct = 0;
      send_item(MODE_BYTE, "k");
      for (int i = 0; i < LF_RUN; i++)
         send_item(MODE_BYTE, CH_LF);
      send_item(MODE_BYTE, "k");
      send_item(MODE_EOB, 8'h00);
      wait_drain(SETTLE_CYCLES);
   endtask

   task automatic send_ws_run(input int n);
      for (int i = 0; i < n; i++)
         send_item(MODE_BYTE, $urandom_range(1) ? CH_SPACE : CH_TAB);
   endtask

   // one line of text: words, whitespace runs, an optional line end, some noise
   task automatic send_random_line();
      int words;
      int r;
      words = $urandom_range(5);
      for (int k = 0; k < words; k++) begin
         send_ws_run($urandom_range(3));
         if ($urandom_range(99) < 10) send_item(MODE_BYTE, CH_CR);
         for (int j = $urandom_range(1, 6); j > 0; j--)
            send_item(MODE_BYTE, 8'($urandom_range(126, 33)));
      end
      if ($urandom_range(99) < 30) send_ws_run($urandom_range(1, 4));
      r = $urandom_range(99);
      if (r < 70)
         send_text("\r\n");
      else if (r < 85)
         send_item(MODE_BYTE, CH_LF);
      else if (r < 92)
         send_item(MODE_BYTE, CH_CR);
      if ($urandom_range(99) < 10)
         for (int j = $urandom_range(1, 4); j > 0; j--)
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      if ($urandom_range(99) < 3)
         for (int j = $urandom_range(12, 24); j > 0; j--)
            send_item(MODE_BYTE, $urandom_range(1) ? CH_CR : CH_SPACE);
      if ($urandom_range(99) < 8)
         send_item(MODE_EOB, 8'($urandom_range(255)));
   endtask

   task automatic test_random_phase(input int idle, input int stall, input int n);
      int start;
      idle_pct = idle;
      stall_pct = stall;
      start = items_sent;
      while (items_sent - start < n)
         send_random_line();
      send_item(MODE_EOB, 8'($urandom_range(255)));
      wait_drain(SETTLE_CYCLES);
   endtask

   initial begin
      canon_clear();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_hold_full();
      test_crlf_run();
      test_random_phase(0, 0, 75);
      test_random_phase(79, 0, 75);
      test_random_phase(0, 79, 75);
      test_random_phase(11, 11, 75);

      $display("run covered %0d input transactions and %0d responses", items_sent,
               results_seen);
      $display("%0d bodies closed, %0d responses flagged overflow, %0d errors",
               bodies_done, ovf_results, errors);
      if (errors == 0)
         $display("PASS dkim_relaxed_body_canon");
      else
         $display("FAIL dkim_relaxed_body_canon");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("FAIL dkim_relaxed_body_canon");
      $finish;
   end

endmodule

>>> filelist.f
rtl/dkimrbc_pkg.sv
rtl/dkimrbc_hold_ram.sv
rtl/dkim_relaxed_body_canon.sv
test/tb_dkim_relaxed_body_canon.sv
